/* src/life_automaton_grid_assert.svh */
// ---------------------------------------------------------------------------
// life_automaton_grid assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_GRID_ASSERT_SVH
`define LIFE_AUTOMATON_GRID_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on clk, held off while arst_n is low.
`define LAG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checked on clk, also during reset.
`define LAG_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LAG_ASSERT(label, prop, msg)
`define LAG_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* src/lag_pkg.sv */
// ---------------------------------------------------------------------------
// lag_pkg
// Shared constants, types and helpers of the life automaton grid.
// ---------------------------------------------------------------------------
`default_nettype none

package lag_pkg;

	localparam int GRID_SIZE  = 16;
	localparam int DUMP_MAX   = 16;
	localparam int DUMP_COUNT = (GRID_SIZE < DUMP_MAX) ? GRID_SIZE : DUMP_MAX;
	localparam int CNT_W      = $clog2(GRID_SIZE);
	localparam int ROW_PAD    = (GRID_SIZE > DUMP_MAX) ? GRID_SIZE : DUMP_MAX;

	localparam logic [1:0] ACT_WRITE   = 2'd0;
	localparam logic [1:0] ACT_ADVANCE = 2'd1;
	localparam logic [1:0] ACT_DUMP    = 2'd2;

	typedef logic [GRID_SIZE-1:0] row_t;

	typedef struct packed {
		logic shift;
		logic wr_alive;
		row_t wr_mask;
	} lag_ctl_t;

	function automatic logic [15:0] to_row_bits(input row_t r);
		logic [ROW_PAD-1:0] pad;
		pad = ROW_PAD'(r);
		return pad[15:0];
	endfunction

endpackage

`default_nettype wire

/* src/lag_row_cell.sv */
// ---------------------------------------------------------------------------
// lag_row_cell
// One grid row; loads from its neighbor on shift, or takes a single-cell write.
// ---------------------------------------------------------------------------
`default_nettype none

module lag_row_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lag_pkg::lag_ctl_t ctl,
	input  wire logic              wr_en,
	input  wire lag_pkg::row_t     shift_in,
	output      lag_pkg::row_t     row_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctl.shift) begin
			row_q <= shift_in;
		end else if (wr_en) begin
			if (ctl.wr_alive) begin
				row_q <= row_q | ctl.wr_mask;
			end else begin
				row_q <= row_q & ~ctl.wr_mask;
			end
		end
	end

endmodule

`default_nettype wire

/* src/lag_rule.sv */
// ---------------------------------------------------------------------------
// lag_rule
// B3/S23 next state of one row from the rows above, at and below it.
// ---------------------------------------------------------------------------
`default_nettype none

module lag_rule (
	input  wire lag_pkg::row_t up,
	input  wire lag_pkg::row_t mid,
	input  wire lag_pkg::row_t down,
	output      lag_pkg::row_t next_row
);

	lag_pkg::row_t up_l, up_r, mid_l, mid_r, down_l, down_r;

	// shifted copies, dead cells enter at the edges
	assign up_l   = up << 1;
	assign up_r   = up >> 1;
	assign mid_l  = mid << 1;
	assign mid_r  = mid >> 1;
	assign down_l = down << 1;
	assign down_r = down >> 1;

	always_comb begin
		logic [3:0] n;
		for (int c = 0; c < lag_pkg::GRID_SIZE; c++) begin
			n = 4'(up_l[c]) + 4'(up[c]) + 4'(up_r[c]) + 4'(mid_l[c]) + 4'(mid_r[c])
				+ 4'(down_l[c]) + 4'(down[c]) + 4'(down_r[c]);
			next_row[c] = (n == 4'd3) || (mid[c] && (n == 4'd2));
		end
	end

endmodule

`default_nettype wire

/* src/life_automaton_grid.sv */
// ---------------------------------------------------------------------------
// life_automaton_grid
// Game of Life grid held in a ring of row cells, written, advanced and dumped.
// ---------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | s_tdata: action, row, col, alive
//  m_*     | out | m_tvalid/m_tready | m_tdata: row_index, row_bits; m_tlast: last
//
//  Write: applied when accepted. Advance: the accept cycle and one turn of
//  the row ring while the rule unit replaces the head row. Dump: one turn
//  of the row ring, one row per cycle through the output register while a
//  low m_tready does not hold it.
//  s_tready is low while an advance or dump is under way.
//  Reset clears the grid to all dead and empties the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module life_automaton_grid (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [15:0] s_tdata,   // action[1:0], row[5:2], col[9:6], alive[10], zero
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [23:0] m_tdata,   // row_index[3:0], row_bits[19:4], zero
	output      logic        m_tlast
);

	`include "life_automaton_grid_assert.svh"

	localparam int N = lag_pkg::GRID_SIZE;
	localparam int W = lag_pkg::CNT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ADV  = 2'd1;
	localparam logic [1:0] ST_DUMP = 2'd2;

	logic [1:0]        state_q;
	logic [W-1:0]      cnt_q;
	lag_pkg::row_t     prev_q;
	lag_pkg::row_t     rows [N];
	lag_pkg::row_t     tail_in;
	lag_pkg::row_t     down_row;
	lag_pkg::row_t     new_row;
	lag_pkg::lag_ctl_t ctl;
	logic [N-1:0]      row_hit;

	logic [1:0]  s_action;
	logic [3:0]  s_row;
	logic [3:0]  s_col;
	logic        s_alive;
	logic        in_acc;
	logic        cnt_end;
	logic        in_dump_range;
	logic        out_free;
	logic        out_load;
	logic        dump_step;
	logic        adv_step;

	logic [3:0]  out_index_q;
	logic [15:0] out_bits_q;
	logic        out_last_q;
	logic        out_valid_q;

	assign s_action = s_tdata[1:0];
	assign s_row    = s_tdata[5:2];
	assign s_col    = s_tdata[9:6];
	assign s_alive  = s_tdata[10];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	assign cnt_end       = (cnt_q == W'(N - 1));
	assign in_dump_range = ({1'b0, cnt_q} < (W + 1)'(lag_pkg::DUMP_COUNT));
	assign out_free      = !out_valid_q || m_tready;
	assign dump_step     = (state_q == ST_DUMP) && (!in_dump_range || out_free);
	assign out_load      = dump_step && in_dump_range;
	assign adv_step      = (state_q == ST_ADV);

	// write decode
	always_comb begin
		ctl.shift    = dump_step || adv_step;
		ctl.wr_alive = s_alive;
		ctl.wr_mask  = (int'(s_col) < N) ? (N'(1) << s_col) : '0;
		for (int i = 0; i < N; i++) begin
			row_hit[i] = in_acc && (s_action == lag_pkg::ACT_WRITE) && (int'(s_row) == i);
		end
	end

	assign down_row = cnt_end ? '0 : rows[1];
	assign tail_in  = adv_step ? new_row : rows[0];

	lag_rule u_rule (
		.up       (prev_q),
		.mid      (rows[0]),
		.down     (down_row),
		.next_row (new_row)
	);

	for (genvar i = 0; i < N; i++) begin : g_row
		lag_row_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_en    (row_hit[i]),
			.shift_in ((i == N - 1) ? tail_in : rows[(i + 1) % N]),
			.row_q    (rows[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc && (s_action == lag_pkg::ACT_ADVANCE)) begin
						state_q <= ST_ADV;
					end else if (in_acc && (s_action == lag_pkg::ACT_DUMP)) begin
						state_q <= ST_DUMP;
					end
				end
				ST_ADV, ST_DUMP: begin
					if (ctl.shift) begin
						cnt_q <= cnt_q + W'(1);
						if (cnt_end) begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// row above the head during an advance, dead above the top row
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			prev_q <= '0;
		end else if (adv_step) begin
			prev_q <= rows[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_index_q <= 4'(cnt_q);
			out_bits_q  <= lag_pkg::to_row_bits(rows[0]);
			out_last_q  <= (cnt_q == W'(lag_pkg::DUMP_COUNT - 1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_bits_q, out_index_q};
	assign m_tlast  = out_last_q;

	`LAG_ASSERT(a_load_in_dump, out_load |-> (state_q == ST_DUMP), "row load outside dump")
	`LAG_ASSERT(a_top_edge_dead, (adv_step && (cnt_q == '0)) |-> (prev_q == '0),
		"row above top row not dead")
	`LAG_ASSERT(a_busy_exit,
		(state_q != ST_IDLE) |=> ((state_q == $past(state_q)) || (state_q == ST_IDLE)),
		"busy state left to other than idle")
	`LAG_ASSERT(a_no_load_stalled, (out_valid_q && !m_tready) |-> !out_load,
		"output register overwritten while stalled")

endmodule

`default_nettype wire

/* tb/sv/life_automaton_grid_tb.sv */
// ---------------------------------------------------------------------------
// life_automaton_grid_tb
// Drives cell writes, generation steps and grid dumps into the stream input,
// keeps its own copy of the grid stepped by the B3/S23 rule, and checks every
// dumped row against it. A directed table opens the run, then random bursts of
// writes around a random spot are stepped and dumped, mixed with noise items.
// ---------------------------------------------------------------------------
module life_automaton_grid_tb;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int RANDOM_ITEMS = 380;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 2 * lag_pkg::GRID_SIZE + 8;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] row;
		logic [3:0] col;
		logic       alive;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  row_index;
		logic [15:0] row_bits;
		logic        last;
	} dump_row_t;

	// typed: every row of this dump must equal typed_bits
	typedef struct packed {
		cmd_t        cmd;
		logic        typed;
		logic [15:0] typed_bits;
	} stim_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;

	lag_pkg::row_t life_grid [lag_pkg::GRID_SIZE];
	lag_pkg::row_t prev_grid [lag_pkg::GRID_SIZE];
	dump_row_t     expected_rows [$];
	int            error_count = 0;
	int            cycle_count = 0;
	bit            quiet = 1'b0;

	stim_t directed_table [23] = '{
		{lag_pkg::ACT_DUMP,    4'd0,  4'd0,  1'b0, 1'b1, 16'h0000},
		{lag_pkg::ACT_WRITE,   4'd0,  4'd0,  1'b1, 1'b0, 16'h0000},
		{lag_pkg::ACT_WRITE,   4'd0,  4'd15, 1'b1, 1'b0, 16'h0000},
		{lag_pkg::ACT_WRITE,   4'd15, 4'd0,  1'b1, 1'b0, 16'h0000},
		{lag_pkg::ACT_WRITE,   4'd15, 4'd15, 1'b1, 1'b0, 16'h0000},
		{lag_pkg::ACT_DUMP,    4'd0,  4'd0,  1'b0, 1'b0, 16'h0000},
		{lag_pkg::ACT_ADVANCE, 4'd15, 4'd15, 1'b1, 1'b0, 16'h0000},
		{lag_pkg::ACT_DUMP,    4'd0,  4'd0,  1'b0, 1'b1, 16'h0000},
		{lag_pkg::ACT_WRITE,   4'd7,  4'd6,  1'b1, 1'b0, 16'h0000},
		{lag_pkg::ACT_WRITE,   4'd7,  4'd7,  1'b1, 1'b0, 16'h0000},
		{lag_pkg::ACT_WRITE,   4'd7,  4'd8,  1'b1, 1'b0, 16'h0000},
		{ACT_NONE,             4'd7,  4'd9,  1'b1, 1'b0, 16'h0000},
		{lag_pkg::ACT_ADVANCE, 4'd0,  4'd0,  1'b0, 1'b0, 16'h0000},
		{lag_pkg::ACT_DUMP,    4'd3,  4'd12, 1'b1, 1'b0, 16'h0000},
		{lag_pkg::ACT_WRITE,   4'd7,  4'd7,  1'b0, 1'b0, 16'h0000},
		{lag_pkg::ACT_DUMP,    4'd15, 4'd0,  1'b1, 1'b0, 16'h0000},
		{lag_pkg::ACT_ADVANCE, 4'd8,  4'd7,  1'b0, 1'b0, 16'h0000},
		{lag_pkg::ACT_DUMP,    4'd0,  4'd0,  1'b0, 1'b1, 16'h0000},
		{lag_pkg::ACT_WRITE,   4'd0,  4'd0,  1'b1, 1'b0, 16'h0000},
		{lag_pkg::ACT_WRITE,   4'd0,  4'd1,  1'b1, 1'b0, 16'h0000},
		{lag_pkg::ACT_WRITE,   4'd1,  4'd0,  1'b1, 1'b0, 16'h0000},
		{lag_pkg::ACT_ADVANCE, 4'd1,  4'd1,  1'b1, 1'b0, 16'h0000},
		{lag_pkg::ACT_DUMP,    4'd0,  4'd0,  1'b0, 1'b0, 16'h0000}
	};

	life_automaton_grid dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic live_at(input int r, input int c);
		if (r < 0 || r >= lag_pkg::GRID_SIZE || c < 0 || c >= lag_pkg::GRID_SIZE)
			return 1'b0;
		return prev_grid[r][c];
	endfunction

	function automatic void next_generation();
		int n;
		for (int r = 0; r < lag_pkg::GRID_SIZE; r++)
			prev_grid[r] = life_grid[r];
		for (int r = 0; r < lag_pkg::GRID_SIZE; r++) begin
			for (int c = 0; c < lag_pkg::GRID_SIZE; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++)
					for (int dc = -1; dc <= 1; dc++)
						if (dr != 0 || dc != 0)
							n += live_at(r + dr, c + dc);
				life_grid[r][c] = prev_grid[r][c] ? (n == 2 || n == 3) : (n == 3);
			end
		end
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0h, expected %0h", what, got, want);
		error_count++;
	endtask

	// entered at a clock edge; returns at the edge where the transaction completed
	task automatic send_cmd(input cmd_t c, input logic typed, input logic [15:0] typed_bits);
		while (!quiet && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, c.alive, c.col, c.row, c.action};
		do @(posedge clk); while (!s_tready);
		case (c.action)
			lag_pkg::ACT_WRITE:   life_grid[c.row][c.col] = c.alive;
			lag_pkg::ACT_ADVANCE: next_generation();
			lag_pkg::ACT_DUMP: begin
				for (int k = 0; k < lag_pkg::DUMP_COUNT; k++)
					expected_rows.push_back({4'(k), typed ? typed_bits : 16'(life_grid[k]),
						k == lag_pkg::DUMP_COUNT - 1});
			end
			default: ;
		endcase
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_rows.size() != 0);
	endtask

	always @(posedge clk) begin
		dump_row_t got;
		dump_row_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[3:0], m_tdata[19:4], m_tlast};
			if (expected_rows.size() == 0) begin
				flag_mismatch("row with none pending", got.row_index, 0);
			end else begin
				want = expected_rows.pop_front();
				if (got.row_index !== want.row_index)
					flag_mismatch("row_index", got.row_index, want.row_index);
				if (got.row_bits !== want.row_bits)
					flag_mismatch("row_bits", got.row_bits, want.row_bits);
				if (got.last !== want.last)
					flag_mismatch("last", got.last, want.last);
			end
		end
		m_tready <= quiet || ($urandom_range(99) >= 16);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		cmd_t       c;
		int         sent;
		int         burst_len;
		int         steps;
		bit         paused;
		logic [3:0] r0;
		logic [3:0] c0;
		for (int r = 0; r < lag_pkg::GRID_SIZE; r++)
			life_grid[r] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_table[i])
			send_cmd(directed_table[i].cmd, directed_table[i].typed,
				directed_table[i].typed_bits);
		hold_until_drained();

		sent   = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			quiet = (sent >= 120 && sent < 220);
			if (!paused && sent >= 300) begin
				hold_until_drained();
				paused = 1'b1;
			end
			if ($urandom_range(99) < 70) begin
				// small random pattern, stepped a few generations, then dumped
				r0 = 4'($urandom);
				c0 = 4'($urandom);
				burst_len = $urandom_range(12, 4);
				repeat (burst_len) begin
					c.action = lag_pkg::ACT_WRITE;
					c.row    = r0 + 4'($urandom_range(4));
					c.col    = c0 + 4'($urandom_range(4));
					c.alive  = ($urandom_range(99) < 75);
					send_cmd(c, 1'b0, 16'h0000);
					sent++;
				end
				steps = $urandom_range(4, 1);
				repeat (steps) begin
					c = 11'($urandom);
					c.action = lag_pkg::ACT_ADVANCE;
					send_cmd(c, 1'b0, 16'h0000);
					sent++;
				end
				c = 11'($urandom);
				c.action = lag_pkg::ACT_DUMP;
				send_cmd(c, 1'b0, 16'h0000);
				sent++;
			end else begin
				c = 11'($urandom);
				send_cmd(c, 1'b0, 16'h0000);
				if (c.action != ACT_NONE)
					sent++;
			end
		end
		quiet = 1'b0;
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/lag_pkg.sv
src/lag_row_cell.sv
src/lag_rule.sv
src/life_automaton_grid.sv
tb/sv/life_automaton_grid_tb.sv
